// File: hdl/dnsc_pkg.sv
// types, constants and helper functions of the nearest-neighbor downscaler
// with alpha blend to rgb565; used by every other file of the block
package dnsc_pkg;

  localparam int unsigned DISP_COLS     = 240;
  localparam int unsigned MAX_IMAGE_DIM = 8191;

  localparam int unsigned DIM_W   = $clog2(MAX_IMAGE_DIM + 1);
  localparam int unsigned DW_W    = 8;
  localparam int unsigned DH_W    = 9;
  localparam int unsigned REM_W   = 9;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned COL_W   = 8;
  localparam int unsigned ROW_W   = 9;
  localparam int unsigned OX_W    = 9;
  localparam int unsigned OY_W    = 10;
  localparam int unsigned SH_W    = 9;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned CIDX_W  = 4;
  localparam int unsigned CDAT_W  = 16;
  localparam int unsigned DIV_STEPS = DIM_W;
  localparam int unsigned DCNT_W  = $clog2(DIV_STEPS);

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [SH_W-1:0] DISP_ROWS_RST = 9'd400;

  typedef enum logic [CIDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 4'd0,
    CFG_IMAGE_HEIGHT  = 4'd1,
    CFG_DRAW_WIDTH    = 4'd2,
    CFG_DRAW_HEIGHT   = 4'd3,
    CFG_ORIGIN_X      = 4'd4,
    CFG_ORIGIN_Y      = 4'd5,
    CFG_DISP_ROWS     = 4'd6,
    CFG_BACKGROUND    = 4'd7
  } dnsc_cfg_e;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DW_W-1:0]  dw;
    logic [DH_W-1:0]  dh;
    logic [DIM_W-1:0] col_q;
    logic [REM_W-1:0] col_r;
    logic [DIM_W-1:0] row_q;
    logic [REM_W-1:0] row_r;
  } dnsc_geom_t;

  typedef struct packed {
    logic [OX_W-1:0] origin_x;
    logic [OY_W-1:0] origin_y;
    logic [SH_W-1:0] disp_rows;
  } dnsc_place_t;

  typedef struct packed {
    logic             picked;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha;
    logic [COL_W-1:0] scol;
    logic [ROW_W-1:0] srow;
    logic             vis;
    logic             frame_end;
  } dnsc_stage_t;

  typedef struct packed {
    logic [DIM_W-1:0] pick;
    logic [REM_W-1:0] rem;
  } dnsc_adv_t;

  // pick += q, rem += r, carry one when rem reaches the draw size
  function automatic dnsc_adv_t dnsc_advance(logic [DIM_W-1:0] pick, logic [REM_W-1:0] rem,
                                             logic [DIM_W-1:0] q, logic [REM_W-1:0] r,
                                             logic [REM_W-1:0] d);
    logic [REM_W:0] sum;
    logic           wrap;
    dnsc_adv_t      res;
    sum = {1'b0, rem} + {1'b0, r};
    wrap = (sum >= {1'b0, d});
    res.rem = wrap ? REM_W'(sum - {1'b0, d}) : sum[REM_W-1:0];
    res.pick = pick + q + DIM_W'(wrap);
    return res;
  endfunction

  // (p*a + bg*(255-a) + 127) / 255, division as (x+1)*257 >> 16
  function automatic logic [CH_W-1:0] dnsc_blend8(logic [CH_W-1:0] p, logic [CH_W-1:0] bg,
                                                  logic [CH_W-1:0] a);
    logic signed [CH_W:0]   diff;
    logic signed [17:0]     prod;
    logic signed [17:0]     x;
    logic        [16:0]     y;
    logic        [24:0]     t;
    diff = $signed({1'b0, p}) - $signed({1'b0, bg});
    prod = $signed({1'b0, a}) * diff;
    x = $signed({2'b0, bg, 8'b0}) - $signed({10'b0, bg}) + 18'sd127 + prod;
    y = {1'b0, x[15:0]} + 17'd1;
    t = {8'b0, y} + {y, 8'b0};
    return t[23:16];
  endfunction

endpackage

// File: hdl/dnsc_if.sv
// channel interfaces of the downscaler: source pixel, result and config write
// depends on dnsc_pkg
interface dnsc_pix_if import dnsc_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface dnsc_res_if import dnsc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_rgb565;
  logic [COL_W-1:0] screen_col;
  logic [ROW_W-1:0] screen_row;
  logic             visible;
  logic             frame_end;
  modport source (output valid, pixel_rgb565, screen_col, screen_row, visible, frame_end,
                  input ready);
  modport sink (input valid, pixel_rgb565, screen_col, screen_row, visible, frame_end,
                output ready);
endinterface

interface dnsc_cfg_if import dnsc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/dnsc_div.sv
// restoring divider, one quotient bit per cycle, for the pick step size
// depends on dnsc_pkg
module dnsc_div import dnsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIM_W-1:0] dividend_i,
  input  logic [REM_W-1:0] divisor_i,
  output logic [DIM_W-1:0] quot_o,
  output logic [REM_W-1:0] rem_o,
  output logic             busy_o
);

  logic              busy_q, busy_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DIM_W-1:0]  dq_q, dq_d;
  logic [REM_W-1:0]  acc_q, acc_d;
  logic [REM_W-1:0]  dvs_q, dvs_d;
  logic [DIM_W-1:0]  quot_q, quot_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [REM_W:0]    trial;
  logic              ge;

  always_comb begin
    trial  = {acc_q, dq_q[DIM_W-1]};
    ge     = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    acc_d  = acc_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      acc_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      acc_d = ge ? REM_W'(trial - {1'b0, dvs_q}) : trial[REM_W-1:0];
      dq_d  = {dq_q[DIM_W-2:0], ge};
      cnt_d = cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        quot_d = dq_d;
        rem_d  = acc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quot_q <= DIM_W'(1);
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    acc_q <= acc_d;
    dvs_q <= dvs_d;
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign busy_o = busy_q;

endmodule

// File: hdl/dnsc_scan.sv
// raster counters and pick decision; registers picked pixels and the frame's last pixel with position
// depends on dnsc_pkg and dnsc_pix_if
module dnsc_scan import dnsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hold_i,
  input  dnsc_geom_t  geom_i,
  input  dnsc_place_t place_i,
  dnsc_pix_if.sink    pix_i,
  output logic        st_valid_o,
  input  logic        st_ready_i,
  output dnsc_stage_t st_o
);

  logic [DIM_W-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [DIM_W-1:0] pick_col_q, pick_col_d, pick_row_q, pick_row_d;
  logic [REM_W-1:0] col_rem_q, col_rem_d, row_rem_q, row_rem_d;
  logic             st_valid_q;
  dnsc_stage_t      st_q, st_d;

  logic             accept, row_picked, col_picked, row_end, last, picked, vis;
  logic [POS_W-1:0] sx, sy;
  dnsc_adv_t        col_adv, row_adv;

  assign pix_i.ready = !hold_i && (!st_valid_q || st_ready_i);
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    row_picked = (src_row_q == pick_row_q) && (out_row_q < geom_i.dh);
    col_picked = (src_col_q == pick_col_q) && (out_col_q < geom_i.dw);
    row_end    = (src_col_q >= geom_i.w - DIM_W'(1));
    last       = row_end && (src_row_q >= geom_i.h - DIM_W'(1));
    picked     = row_picked && col_picked;

    sx  = {{(POS_W-OX_W){place_i.origin_x[OX_W-1]}}, place_i.origin_x}
          + {{(POS_W-COL_W){1'b0}}, out_col_q};
    sy  = {{(POS_W-OY_W){place_i.origin_y[OY_W-1]}}, place_i.origin_y}
          + {{(POS_W-ROW_W){1'b0}}, out_row_q};
    vis = picked && !sx[POS_W-1] && (sx < POS_W'(DISP_COLS))
          && !sy[POS_W-1] && (sy < {{(POS_W-SH_W){1'b0}}, place_i.disp_rows});

    st_d.picked    = picked;
    st_d.red       = pix_i.red;
    st_d.green     = pix_i.green;
    st_d.blue      = pix_i.blue;
    st_d.alpha     = pix_i.alpha;
    st_d.vis       = vis;
    st_d.scol      = vis ? sx[COL_W-1:0] : '0;
    st_d.srow      = vis ? sy[ROW_W-1:0] : '0;
    st_d.frame_end = last;

    col_adv = dnsc_advance(pick_col_q, col_rem_q, geom_i.col_q, geom_i.col_r,
                           {{(REM_W-DW_W){1'b0}}, geom_i.dw});
    row_adv = dnsc_advance(pick_row_q, row_rem_q, geom_i.row_q, geom_i.row_r, geom_i.dh);

    src_col_d  = src_col_q;
    src_row_d  = src_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    pick_col_d = pick_col_q;
    pick_row_d = pick_row_q;
    col_rem_d  = col_rem_q;
    row_rem_d  = row_rem_q;

    if (col_picked) begin
      pick_col_d = col_adv.pick;
      col_rem_d  = col_adv.rem;
      out_col_d  = out_col_q + COL_W'(1);
    end

    if (last) begin
      src_col_d  = '0;
      src_row_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      pick_col_d = '0;
      pick_row_d = '0;
      col_rem_d  = '0;
      row_rem_d  = '0;
    end else if (row_end) begin
      src_col_d  = '0;
      out_col_d  = '0;
      pick_col_d = '0;
      col_rem_d  = '0;
      if (row_picked) begin
        pick_row_d = row_adv.pick;
        row_rem_d  = row_adv.rem;
        out_row_d  = out_row_q + ROW_W'(1);
      end
      src_row_d = src_row_q + DIM_W'(1);
    end else begin
      src_col_d = src_col_q + DIM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q  <= '0;
      src_row_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      pick_col_q <= '0;
      pick_row_q <= '0;
      col_rem_q  <= '0;
      row_rem_q  <= '0;
      st_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        src_col_q  <= src_col_d;
        src_row_q  <= src_row_d;
        out_col_q  <= out_col_d;
        out_row_q  <= out_row_d;
        pick_col_q <= pick_col_d;
        pick_row_q <= pick_row_d;
        col_rem_q  <= col_rem_d;
        row_rem_q  <= row_rem_d;
      end
      if (!st_valid_q || st_ready_i) begin
        st_valid_q <= accept && (picked || last);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q <= st_d;
    end
  end

  assign st_valid_o = st_valid_q;
  assign st_o       = st_q;

endmodule

// File: hdl/dnsc_blend.sv
// alpha blend over the expanded background, rgb565 packing, result register
// depends on dnsc_pkg and dnsc_res_if
module dnsc_blend import dnsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PIX_W-1:0] bg_i,
  input  logic             st_valid_i,
  output logic             st_ready_o,
  input  dnsc_stage_t      st_i,
  dnsc_res_if.source       res_o
);

  logic             out_valid_q;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic [COL_W-1:0] scol_q;
  logic [ROW_W-1:0] srow_q;
  logic             vis_q, fend_q;
  logic [CH_W-1:0]  bg_r, bg_g, bg_b, r8, g8, b8;
  logic             load;

  assign st_ready_o = !out_valid_q || res_o.ready;
  assign load       = st_valid_i && st_ready_o;

  always_comb begin
    bg_r = {bg_i[15:11], bg_i[15:13]};
    bg_g = {bg_i[10:5], bg_i[10:9]};
    bg_b = {bg_i[4:0], bg_i[4:2]};
    if (st_i.alpha == ALPHA_OPAQUE) begin
      r8 = st_i.red;
      g8 = st_i.green;
      b8 = st_i.blue;
    end else begin
      r8 = dnsc_blend8(st_i.red, bg_r, st_i.alpha);
      g8 = dnsc_blend8(st_i.green, bg_g, st_i.alpha);
      b8 = dnsc_blend8(st_i.blue, bg_b, st_i.alpha);
    end
    pix_d = st_i.picked ? {r8[7:3], g8[7:2], b8[7:3]} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_ready_o) begin
      out_valid_q <= st_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q  <= pix_d;
      scol_q <= st_i.scol;
      srow_q <= st_i.srow;
      vis_q  <= st_i.vis;
      fend_q <= st_i.frame_end;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.pixel_rgb565 = pix_q;
  assign res_o.screen_col   = scol_q;
  assign res_o.screen_row   = srow_q;
  assign res_o.visible      = vis_q;
  assign res_o.frame_end    = fend_q;

endmodule

// File: hdl/nearest_downscale_alpha_rgb565_core.sv
// nearest-neighbor downscaler with alpha blend to rgb565, top level
// an item is registered in the scan stage and then in the blend result register
// throughput: one item per cycle unless res_o.ready stalls; after a write to a size
// register the input is held off while the step dividers run one bit per cycle
// reset: counters at zero, registers at their reset values, no clearing pass
// depends on dnsc_pkg, dnsc_if, dnsc_div, dnsc_scan and dnsc_blend
module nearest_downscale_alpha_rgb565_core import dnsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dnsc_pix_if.sink   pix_i,
  dnsc_res_if.source res_o,
  dnsc_cfg_if.sink   cfg_i
);

  logic [DIM_W-1:0]  image_width_q, image_height_q;
  logic [DW_W-1:0]   draw_width_q;
  logic [DH_W-1:0]   draw_height_q;
  logic [OX_W-1:0]   origin_x_q;
  logic [OY_W-1:0]   origin_y_q;
  logic [SH_W-1:0]   disp_rows_q;
  logic [PIX_W-1:0]  background_q;
  logic              restart_q;

  logic              cfg_wr, size_wr;
  logic [DIM_W-1:0]  w, h;
  logic [DW_W-1:0]   dw1, dw;
  logic [DH_W-1:0]   dh1, dh;
  logic              col_busy, row_busy;
  logic [DIM_W-1:0]  col_step, row_step;
  logic [REM_W-1:0]  col_frac, row_frac;
  dnsc_geom_t        geom;
  dnsc_place_t       place;
  logic              st_valid, st_ready;
  dnsc_stage_t       st;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign size_wr     = cfg_wr && ((cfg_i.index == CFG_IMAGE_WIDTH)
                       || (cfg_i.index == CFG_IMAGE_HEIGHT)
                       || (cfg_i.index == CFG_DRAW_WIDTH)
                       || (cfg_i.index == CFG_DRAW_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= DIM_W'(1);
      image_height_q  <= DIM_W'(1);
      draw_width_q    <= DW_W'(1);
      draw_height_q   <= DH_W'(1);
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      disp_rows_q     <= DISP_ROWS_RST;
      background_q    <= '0;
      restart_q       <= 1'b0;
    end else begin
      restart_q <= size_wr;
      if (cfg_wr) begin
        case (cfg_i.index)
          CFG_IMAGE_WIDTH:   image_width_q   <= cfg_i.data[DIM_W-1:0];
          CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_i.data[DIM_W-1:0];
          CFG_DRAW_WIDTH:    draw_width_q    <= cfg_i.data[DW_W-1:0];
          CFG_DRAW_HEIGHT:   draw_height_q   <= cfg_i.data[DH_W-1:0];
          CFG_ORIGIN_X:      origin_x_q      <= cfg_i.data[OX_W-1:0];
          CFG_ORIGIN_Y:      origin_y_q      <= cfg_i.data[OY_W-1:0];
          CFG_DISP_ROWS:     disp_rows_q     <= cfg_i.data[SH_W-1:0];
          CFG_BACKGROUND:    background_q    <= cfg_i.data[PIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // zero sizes act as one, draw sizes clamped to the image
  always_comb begin
    w   = (image_width_q == '0) ? DIM_W'(1) : image_width_q;
    h   = (image_height_q == '0) ? DIM_W'(1) : image_height_q;
    dw1 = (draw_width_q == '0) ? DW_W'(1) : draw_width_q;
    dh1 = (draw_height_q == '0) ? DH_W'(1) : draw_height_q;
    dw  = ({{(DIM_W-DW_W){1'b0}}, dw1} > w) ? w[DW_W-1:0] : dw1;
    dh  = ({{(DIM_W-DH_W){1'b0}}, dh1} > h) ? h[DH_W-1:0] : dh1;
  end

  dnsc_div u_col_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (restart_q),
    .dividend_i (w),
    .divisor_i  ({{(REM_W-DW_W){1'b0}}, dw}),
    .quot_o     (col_step),
    .rem_o      (col_frac),
    .busy_o     (col_busy)
  );

  dnsc_div u_row_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (restart_q),
    .dividend_i (h),
    .divisor_i  (dh),
    .quot_o     (row_step),
    .rem_o      (row_frac),
    .busy_o     (row_busy)
  );

  assign geom = '{w: w, h: h, dw: dw, dh: dh, col_q: col_step, col_r: col_frac,
                  row_q: row_step, row_r: row_frac};

  assign place = '{origin_x: origin_x_q, origin_y: origin_y_q, disp_rows: disp_rows_q};

  dnsc_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hold_i     (restart_q || col_busy || row_busy),
    .geom_i     (geom),
    .place_i    (place),
    .pix_i      (pix_i),
    .st_valid_o (st_valid),
    .st_ready_i (st_ready),
    .st_o       (st)
  );

  dnsc_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bg_i       (background_q),
    .st_valid_i (st_valid),
    .st_ready_o (st_ready),
    .st_i       (st),
    .res_o      (res_o)
  );

`ifndef ASSERT_OFF
  a_size_write_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_wr |=> !pix_i.ready)
    else $error("input taken right after a size register write");

  a_hidden_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.visible |-> res_o.screen_col == '0 && res_o.screen_row == '0)
    else $error("hidden result carries a screen position");

  a_row_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.visible |-> res_o.screen_row < disp_rows_q
                                  && res_o.screen_col < COL_W'(DISP_COLS))
    else $error("visible result lies off screen");

  a_no_input_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_busy || row_busy) |-> !pix_i.ready)
    else $error("input taken while step size is computed");
`endif

endmodule
